// ----- design/scd_pkg.sv -----
// ----------------------------------------------------------------------------
// scd_pkg: shared types and constants of the stereo chorus delay core
// widths, register codes, reset values and the sine lookup table
// ----------------------------------------------------------------------------
package scd_pkg;

   localparam int DELAY_ENTRIES = 16384;
   localparam int DELAY_AW      = $clog2(DELAY_ENTRIES);
   localparam int SAMPLE_BITS   = 16;
   localparam int SINE_ENTRIES  = 1024;
   localparam int SINE_AW       = $clog2(SINE_ENTRIES);

   localparam int DELAY_W     = 21;
   localparam int LEVEL_W     = 16;
   localparam int STEP_W      = 31;
   localparam int PHASE_W     = 32;
   localparam int CSR_DATA_W  = 31;
   localparam int CSR_INDEX_W = 2;

   // oscillator is signed q16, -1.0 .. +1.0
   localparam int OSC_W     = 18;
   localparam int OSC_FRAC  = 16;
   localparam int MOD_W     = OSC_W - 1;
   localparam int MP_W      = DELAY_W + MOD_W;
   localparam int FRAC_W    = 8;
   localparam int OFFS_W    = DELAY_W + 1;
   localparam int BLEND_W   = SAMPLE_BITS + FRAC_W + 2;
   localparam int PROD_W    = BLEND_W + LEVEL_W + 1;
   localparam int WET_SHIFT = FRAC_W + LEVEL_W;
   localparam int WET_W     = PROD_W - WET_SHIFT;
   localparam int SUM_W     = WET_W + 1;

   localparam logic [CSR_INDEX_W-1:0] CSR_BASE_DELAY = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MOD_DEPTH  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_WET_LEVEL  = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_PHASE_STEP = 2'd3;

   localparam logic [DELAY_W-1:0] BASE_DELAY_RESET = 21'd245760;
   localparam logic [DELAY_W-1:0] MOD_DEPTH_RESET  = 21'd73728;
   localparam logic [LEVEL_W-1:0] WET_LEVEL_RESET  = 16'd26214;
   localparam logic [STEP_W-1:0]  PHASE_STEP_RESET = 31'd26844;

   typedef logic signed [SAMPLE_BITS-1:0] sample_type;
   typedef logic signed [OSC_W-1:0]       osc_type;
   typedef logic [DELAY_AW-1:0]           addr_type;

   typedef struct packed {
      logic [DELAY_W-1:0] base_delay;
      logic [DELAY_W-1:0] mod_depth;
      logic [LEVEL_W-1:0] wet_level;
      logic [STEP_W-1:0]  phase_step;
   } cfg_type;

   // one-hot step strobes from the sequencer to the lanes
   typedef struct packed {
      logic start;
      logic first;
      logic second;
      logic scale;
   } lane_ctl_type;

   typedef struct packed {
      sample_type              dry;
      logic signed [WET_W-1:0] wet;
   } lane_res_type;

   // quarter-wave polynomial coefficients, q16
   localparam longint unsigned POLY_A = 102944;
   localparam longint unsigned POLY_B = 42048;
   localparam longint unsigned POLY_C = 4640;

   typedef osc_type sine_rom_type [SINE_ENTRIES];

   function automatic sine_rom_type build_sine_rom();
      sine_rom_type    rom;
      longint unsigned p;
      longint unsigned quad;
      longint unsigned t;
      longint unsigned t2;
      longint unsigned inner;
      longint unsigned mid;
      longint unsigned s;
      for (int i = 0; i < SINE_ENTRIES; i++) begin
         p    = (longint'(i) << 18) / SINE_ENTRIES;
         quad = (p >> 16) & 64'd3;
         t    = p & 64'hFFFF;
         // odd quadrants run the quarter wave backwards
         if ((quad & 64'd1) != 64'd0) begin
            t = 64'd65536 - t;
         end
         t2    = (t * t) >> 16;
         inner = POLY_B - ((t2 * POLY_C) >> 16);
         mid   = POLY_A - ((t2 * inner) >> 16);
         s     = (t * mid) >> 16;
         if (s > 64'd65536) begin
            s = 64'd65536;
         end
         // upper half of the turn is negative
         if ((quad & 64'd2) != 64'd0) begin
            rom[i] = osc_type'(64'd0 - s);
         end else begin
            rom[i] = osc_type'(s);
         end
      end
      return rom;
   endfunction

   localparam sine_rom_type SINE_ROM = build_sine_rom();

endpackage

// ----- design/scd_lfo.sv -----
// ----------------------------------------------------------------------------
// scd_lfo: quadrature low-frequency oscillator
// phase accumulator with registered cosine and sine table lookups
// ----------------------------------------------------------------------------
module scd_lfo import scd_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  logic [STEP_W-1:0] phase_step,
   output osc_type           osc_cos,
   output osc_type           osc_sin
);

   localparam logic [PHASE_W-1:0] QUARTER_TURN = PHASE_W'(1) << (PHASE_W - 2);

   logic [PHASE_W-1:0] phase_ff;
   logic [PHASE_W-1:0] phase_in;
   logic [PHASE_W-1:0] cos_phase;
   logic [SINE_AW-1:0] cos_idx;
   logic [SINE_AW-1:0] sin_idx;
   osc_type            cos_ff;
   osc_type            sin_ff;

   assign phase_in  = phase_ff + PHASE_W'(phase_step);
   assign cos_phase = phase_ff + QUARTER_TURN;
   assign cos_idx   = cos_phase[PHASE_W-1 -: SINE_AW];
   assign sin_idx   = phase_ff[PHASE_W-1 -: SINE_AW];

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= '0;
      end else if (advance) begin
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      cos_ff <= SINE_ROM[cos_idx];
      sin_ff <= SINE_ROM[sin_idx];
   end

   assign osc_cos = cos_ff;
   assign osc_sin = sin_ff;

endmodule

// ----- design/scd_lane.sv -----
// ----------------------------------------------------------------------------
// scd_lane: one channel of the chorus
// delay memory, modulated read offset, linear blend and wet gain
// ----------------------------------------------------------------------------
module scd_lane import scd_pkg::*; (
   input  logic         clock,
   input  lane_ctl_type ctl,
   input  cfg_type      cfg,
   input  addr_type     wr_pos,
   input  logic         full,
   input  osc_type      osc,
   input  sample_type   dry,
   output lane_res_type res
);

   localparam logic [OSC_W:0]    OSC_ONE  = (OSC_W + 1)'(1) << OSC_FRAC;
   localparam logic [FRAC_W:0]   FRAC_ONE = (FRAC_W + 1)'(1) << FRAC_W;
   localparam logic [PROD_W-1:0] ROUND    = PROD_W'(1) << (WET_SHIFT - 1);

   sample_type delay_mem_ff [DELAY_ENTRIES];

   logic [OSC_W:0]              osc_bias;
   logic [MOD_W-1:0]            mod_frac;
   logic [MP_W-1:0]             mod_prod;
   logic [OFFS_W-1:0]           offs_in;
   logic [OFFS_W-1:0]           offs_ff;
   addr_type                    p0;
   addr_type                    p1;
   addr_type                    p1_ff;
   logic [FRAC_W-1:0]           frac_ff;
   logic                        valid0_ff;
   logic                        valid1_ff;
   logic                        bypass_ff;
   sample_type                  rdata_ff;
   sample_type                  dry_ff;
   sample_type                  x0;
   sample_type                  x1;
   logic [FRAC_W:0]             w0;
   logic signed [BLEND_W-1:0]   term0;
   logic signed [BLEND_W-1:0]   term1;
   logic signed [BLEND_W-1:0]   acc_ff;
   logic signed [PROD_W-1:0]    prod_ff;

   // oscillator mapped to 0..1 q16, then scaled by the depth
   assign osc_bias = {osc[OSC_W-1], osc} + OSC_ONE;
   assign mod_frac = osc_bias[OSC_W-1:1];
   assign mod_prod = MP_W'(cfg.mod_depth) * MP_W'(mod_frac);
   assign offs_in  = OFFS_W'(cfg.base_delay) + OFFS_W'(mod_prod[MP_W-1:OSC_FRAC]);

   // offset tracks config and oscillator continuously
   always_ff @(posedge clock) begin
      offs_ff <= offs_in;
   end

   assign p0 = wr_pos - offs_ff[FRAC_W +: DELAY_AW];
   assign p1 = p0 - addr_type'(1);

   // whole delay of zero reads the sample being written
   assign x0 = bypass_ff ? dry_ff : (valid0_ff ? rdata_ff : sample_type'(0));
   assign x1 = valid1_ff ? rdata_ff : sample_type'(0);
   assign w0 = FRAC_ONE - {1'b0, frac_ff};

   assign term0 = BLEND_W'(x0) * BLEND_W'($signed({1'b0, w0}));
   assign term1 = BLEND_W'(x1) * BLEND_W'($signed({1'b0, frac_ff}));

   always_ff @(posedge clock) begin
      if (ctl.start) begin
         delay_mem_ff[wr_pos] <= dry;
         rdata_ff             <= delay_mem_ff[p0];
      end else if (ctl.first) begin
         rdata_ff <= delay_mem_ff[p1_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.start) begin
         dry_ff    <= dry;
         frac_ff   <= offs_ff[FRAC_W-1:0];
         p1_ff     <= p1;
         // entries above the write pointer are unwritten until the first wrap
         valid0_ff <= full || (p0 <= wr_pos);
         valid1_ff <= full || (p1 <= wr_pos);
         bypass_ff <= (p0 == wr_pos);
      end
      if (ctl.first) begin
         acc_ff <= term0;
      end else if (ctl.second) begin
         acc_ff <= acc_ff + term1;
      end
      if (ctl.scale) begin
         prod_ff <= PROD_W'(acc_ff) * PROD_W'($signed({1'b0, cfg.wet_level})) + ROUND;
      end
   end

   assign res.dry = dry_ff;
   assign res.wet = prod_ff[PROD_W-1 -: WET_W];

endmodule

// ----- design/scd_merge.sv -----
// ----------------------------------------------------------------------------
// scd_merge: output stage
// adds wet to dry per channel, saturates, holds the response register
// ----------------------------------------------------------------------------
module scd_merge import scd_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         load,
   input  lane_res_type left_res,
   input  lane_res_type right_res,
   input  logic         rsp_ready,
   output logic         rsp_valid,
   output sample_type   rsp_left_out,
   output sample_type   rsp_right_out
);

   localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'((1 << (SAMPLE_BITS - 1)) - 1);
   localparam logic signed [SUM_W-1:0] SAT_LO = -SUM_W'(1 << (SAMPLE_BITS - 1));

   function automatic sample_type mix_sat(lane_res_type r);
      logic signed [SUM_W-1:0] sum;
      sum = SUM_W'(r.dry) + SUM_W'(r.wet);
      priority if (sum > SAT_HI) begin
         return SAT_HI[SAMPLE_BITS-1:0];
      end else if (sum < SAT_LO) begin
         return SAT_LO[SAMPLE_BITS-1:0];
      end else begin
         return sum[SAMPLE_BITS-1:0];
      end
   endfunction

   logic       valid_ff;
   sample_type left_ff;
   sample_type right_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         left_ff  <= mix_sat(left_res);
         right_ff <= mix_sat(right_res);
      end
   end

   assign rsp_valid     = valid_ff;
   assign rsp_left_out  = left_ff;
   assign rsp_right_out = right_ff;

endmodule

// ----- design/stereo_chorus_delay_core.sv -----
// ----------------------------------------------------------------------------
// stereo_chorus_delay_core: stereo chorus on a modulated delay line
// an accepted request walks the first, second and scale states; done then loads the response register once free
// the next request is taken in done at the earliest, after the four lane steps accept to scale
// reset: memory kept, requests wait to settle, control and registers to defaults, register codes 0 to 3
// ----------------------------------------------------------------------------
module stereo_chorus_delay_core import scd_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   // request channel
   input  logic                   req_valid,
   output logic                   req_ready,
   input  sample_type             req_left_in,
   input  sample_type             req_right_in,
   // response channel
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output sample_type             rsp_left_out,
   output sample_type             rsp_right_out,
   // register write port
   input  logic                   csr_write_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   // request walk through the lanes:
   //   accept : sample written, first tap read, lfo phase advanced
   //   first  : second tap read, first blend product
   //   second : second blend product accumulated
   //   scale  : wet gain applied with rounding
   //   done   : both channels mixed into the response register
   // a new request is taken in done as soon as the response register frees up and the offsets have settled
   typedef enum logic [2:0] {
      S_IDLE,
      S_FIRST,
      S_SECOND,
      S_SCALE,
      S_DONE
   } state_type;

   localparam logic [1:0] SETTLE_CYCLES = 2'd2;

   state_type    state_ff;
   state_type    state_in;
   cfg_type      cfg_ff;
   addr_type     wp_ff;
   logic         full_ff;
   logic [1:0]   settle_ff;
   logic         accept;
   logic         out_free;
   logic         load;
   lane_ctl_type lane_ctl;
   osc_type      osc_cos;
   osc_type      osc_sin;
   lane_res_type left_res;
   lane_res_type right_res;

   // response register can take a new value this cycle
   assign out_free = !rsp_valid || rsp_ready;
   assign load     = (state_ff == S_DONE) && out_free;

   // requests wait until the lane offset registers have followed a phase or config change
   assign req_ready = ((state_ff == S_IDLE) || load) && (settle_ff == 2'd0);
   assign accept    = req_valid && req_ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:   if (accept) state_in = S_FIRST;
         S_FIRST:  state_in = S_SECOND;
         S_SECOND: state_in = S_SCALE;
         S_SCALE:  state_in = S_DONE;
         S_DONE: begin
            if (accept) begin
               state_in = S_FIRST;
            end else if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default:  state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         settle_ff <= SETTLE_CYCLES;
         wp_ff     <= '0;
         full_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_write_en || accept) begin
            settle_ff <= SETTLE_CYCLES;
         end else if (settle_ff != 2'd0) begin
            settle_ff <= settle_ff - 2'd1;
         end
         // write pointer doubles as fill count until the first wrap
         if (accept) begin
            wp_ff <= wp_ff + addr_type'(1);
            if (wp_ff == '1) begin
               full_ff <= 1'b1;
            end
         end
      end
   end

   // configuration registers, values masked to their widths
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.base_delay <= BASE_DELAY_RESET;
         cfg_ff.mod_depth  <= MOD_DEPTH_RESET;
         cfg_ff.wet_level  <= WET_LEVEL_RESET;
         cfg_ff.phase_step <= PHASE_STEP_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_BASE_DELAY: cfg_ff.base_delay <= csr_wdata[DELAY_W-1:0];
            CSR_MOD_DEPTH:  cfg_ff.mod_depth  <= csr_wdata[DELAY_W-1:0];
            CSR_WET_LEVEL:  cfg_ff.wet_level  <= csr_wdata[LEVEL_W-1:0];
            CSR_PHASE_STEP: cfg_ff.phase_step <= csr_wdata[STEP_W-1:0];
         endcase
      end
   end

   assign lane_ctl.start  = accept;
   assign lane_ctl.first  = (state_ff == S_FIRST);
   assign lane_ctl.second = (state_ff == S_SECOND);
   assign lane_ctl.scale  = (state_ff == S_SCALE);

   // phase steps once per request; cosine drives left, sine drives right
   scd_lfo u_lfo (
      .clock      (clock),
      .reset      (reset),
      .advance    (accept),
      .phase_step (cfg_ff.phase_step),
      .osc_cos    (osc_cos),
      .osc_sin    (osc_sin)
   );

   scd_lane u_lane_left (
      .clock  (clock),
      .ctl    (lane_ctl),
      .cfg    (cfg_ff),
      .wr_pos (wp_ff),
      .full   (full_ff),
      .osc    (osc_cos),
      .dry    (req_left_in),
      .res    (left_res)
   );

   scd_lane u_lane_right (
      .clock  (clock),
      .ctl    (lane_ctl),
      .cfg    (cfg_ff),
      .wr_pos (wp_ff),
      .full   (full_ff),
      .osc    (osc_sin),
      .dry    (req_right_in),
      .res    (right_res)
   );

   scd_merge u_merge (
      .clock         (clock),
      .reset         (reset),
      .load          (load),
      .left_res      (left_res),
      .right_res     (right_res),
      .rsp_ready     (rsp_ready),
      .rsp_valid     (rsp_valid),
      .rsp_left_out  (rsp_left_out),
      .rsp_right_out (rsp_right_out)
   );

   // once the ring has wrapped every entry stays written
   a_full_sticky: assert property (@(posedge clock) disable iff (reset)
      full_ff |=> full_ff)
      else $error("fill flag dropped after the ring wrapped");

   // a finished request with room downstream always lands in the response register
   a_done_loads: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE) && out_free |=> rsp_valid)
      else $error("finished request not delivered to the response register");

   // no new request while a finished one is blocked downstream
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE) && rsp_valid && !rsp_ready |-> !req_ready)
      else $error("request accepted while the previous result is stuck");

   // write pointer moves by exactly one per accepted request
   a_wp_step: assert property (@(posedge clock) disable iff (reset)
      accept |=> wp_ff == $past(wp_ff) + addr_type'(1))
      else $error("write pointer out of step with accepted requests");

endmodule

// ----- tb/sv/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the stereo chorus delay core
// a clocked driver sends stereo requests from a pending queue while a monitor
// predicts each response from a bit-true chorus model kept in the bench and
// compares it with what the core returns; register settings change between
// phases, and both channels idle and stall at random
// ----------------------------------------------------------------------------
module testbench;
   import scd_pkg::*;

   // bench limits
   localparam int STALL_LIMIT   = 2000;  // cycles with no transfer before giving up
   localparam int SETTLE_CYCLES = 10;    // quiet time after the last response
   localparam int LONG_HOLD     = 400;   // receiver back-pressure stretch
   localparam int PHASES        = 10;
   localparam int PHASE_ITEMS   = 134;

   // quarter-wave sine polynomial, q16
   localparam longint LFO_A = 102944;
   localparam longint LFO_B = 42048;
   localparam longint LFO_C = 4640;

   localparam sample_type SAMPLE_MAX = 16'sh7FFF;
   localparam sample_type SAMPLE_MIN = 16'sh8000;

   typedef struct packed {
      sample_type left;
      sample_type right;
   } stereo_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   sample_type             req_left_in = '0;
   sample_type             req_right_in = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   sample_type             rsp_left_out;
   sample_type             rsp_right_out;
   logic                   csr_write_en = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = CSR_BASE_DELAY;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   stereo_chorus_delay_core u_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_left_in   (req_left_in),
      .req_right_in  (req_right_in),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_left_out  (rsp_left_out),
      .rsp_right_out (rsp_right_out),
      .csr_write_en  (csr_write_en),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // requests waiting to be sent, responses waiting to arrive
   stereo_type pending_pairs[$];
   stereo_type expected_out[$];

   int  requests_queued = 0;
   int  requests_taken  = 0;
   int  errors          = 0;
   int  idle_cycles     = 0;
   int  send_gap        = 0;
   int  stall_left      = 0;
   int  hold_asks       = 0;
   int  hold_seen       = 0;
   bit  steady_mode     = 1'b0;   // no gaps on either side while set
   bit  req_taken       = 1'b0;
   bit  rsp_taken       = 1'b0;

   // chorus state mirrored in the bench
   sample_type store_left  [DELAY_ENTRIES];
   sample_type store_right [DELAY_ENTRIES];
   addr_type   write_ptr;
   logic [31:0] lfo_phase;
   cfg_type    model_cfg;

   // mostly short gaps, now and then a long one
   function automatic int idle_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 65) return 0;
      if (roll < 95) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic sample_type any_sample();
      case ($urandom_range(0, 9))
         0: return ($urandom_range(0, 1) != 0) ? SAMPLE_MAX : SAMPLE_MIN;
         1: return sample_type'($urandom_range(0, 1) != 0 ? -1 : 0);
         default: return sample_type'($urandom);
      endcase
   endfunction

   // oscillator in signed q16: table index is the top 10 phase bits
   function automatic longint lfo_value(logic [31:0] phase);
      logic [9:0] idx;
      longint     t;
      longint     t2;
      longint     inner;
      longint     mid;
      longint     s;
      idx = phase[31:22];
      t   = longint'(idx[7:0]) << 8;
      // second and fourth quarters run backwards
      if (idx[8]) t = 65536 - t;
      t2    = (t * t) >>> 16;
      inner = LFO_B - ((t2 * LFO_C) >>> 16);
      mid   = LFO_A - ((t2 * inner) >>> 16);
      s     = (t * mid) >>> 16;
      if (s > 65536) s = 65536;
      return idx[9] ? -s : s;
   endfunction

   // one channel: modulated tap, linear blend, wet gain, saturating mix
   function automatic sample_type lane_out(longint dry, longint osc, bit right_lane);
      longint   m;
      longint   offs;
      longint   whole;
      longint   frac;
      longint   x0;
      longint   x1;
      longint   blend;
      longint   prod;
      longint   sum;
      addr_type p0;
      addr_type p1;
      m     = (osc + 65536) >>> 1;
      offs  = longint'(model_cfg.base_delay)
              + ((longint'(model_cfg.mod_depth) * m) >>> 16);
      whole = offs >>> 8;
      frac  = offs & 255;
      p0    = addr_type'(longint'(write_ptr) - whole);
      p1    = p0 - 1'b1;
      x0    = longint'(right_lane ? store_right[p0] : store_left[p0]);
      x1    = longint'(right_lane ? store_right[p1] : store_left[p1]);
      blend = x0 * (256 - frac) + x1 * frac;
      prod  = blend * longint'(model_cfg.wet_level) + 8388608;
      sum   = dry + (prod >>> 24);
      if (sum > 32767) sum = 32767;
      if (sum < -32768) sum = -32768;
      return sample_type'(sum);
   endfunction

   // store first, oscillator from the old phase, then advance
   function automatic void chorus_predict(sample_type dry_l, sample_type dry_r);
      stereo_type res;
      store_left[write_ptr]  = dry_l;
      store_right[write_ptr] = dry_r;
      res.left  = lane_out(longint'(dry_l), lfo_value(lfo_phase + 32'h4000_0000), 1'b0);
      res.right = lane_out(longint'(dry_r), lfo_value(lfo_phase), 1'b1);
      lfo_phase = lfo_phase + {1'b0, model_cfg.phase_step};
      write_ptr = write_ptr + 1'b1;
      expected_out.push_back(res);
   endfunction

   // request driver: holds each request until it is taken, then maybe idles
   always @(negedge clock) begin : driver
      stereo_type next_pair;
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
      end else if (!req_valid || req_taken) begin
         if (send_gap > 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (pending_pairs.size() != 0) begin
            next_pair = pending_pairs.pop_front();
            req_valid    <= 1'b1;
            req_left_in  <= next_pair.left;
            req_right_in <= next_pair.right;
            send_gap = steady_mode ? 0 : idle_gap();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // response side back-pressure, with a long hold when the stimulus asks
   always @(negedge clock) begin : receiver
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_asks != hold_seen) begin
         hold_seen  = hold_asks;
         stall_left = LONG_HOLD;
         rsp_ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
         stall_left = steady_mode ? 0 : idle_gap();
      end
   end

   // monitor: register mirror, prediction on accepted requests, response check
   always @(posedge clock) begin : monitor
      stereo_type want;
      if (reset) begin
         req_taken = 1'b0;
         rsp_taken = 1'b0;
         for (int i = 0; i < DELAY_ENTRIES; i++) begin
            store_left[i]  = '0;
            store_right[i] = '0;
         end
         write_ptr            = '0;
         lfo_phase            = '0;
         model_cfg.base_delay = BASE_DELAY_RESET;
         model_cfg.mod_depth  = MOD_DEPTH_RESET;
         model_cfg.wet_level  = WET_LEVEL_RESET;
         model_cfg.phase_step = PHASE_STEP_RESET;
      end else begin
         req_taken = req_valid && req_ready;
         rsp_taken = rsp_valid && rsp_ready;

         // written values are cut to the register widths
         if (csr_write_en) begin
            case (csr_index)
               CSR_BASE_DELAY: model_cfg.base_delay = csr_wdata[DELAY_W-1:0];
               CSR_MOD_DEPTH:  model_cfg.mod_depth  = csr_wdata[DELAY_W-1:0];
               CSR_WET_LEVEL:  model_cfg.wet_level  = csr_wdata[LEVEL_W-1:0];
               CSR_PHASE_STEP: model_cfg.phase_step = csr_wdata[STEP_W-1:0];
               default: ;
            endcase
         end

         if (req_taken) begin
            chorus_predict(req_left_in, req_right_in);
            requests_taken++;
         end

         if (rsp_taken) begin
            if (expected_out.size() == 0) begin
               $display("%0t: response with none expected, actual %0d %0d",
                        $time, rsp_left_out, rsp_right_out);
               errors++;
            end else begin
               want = expected_out.pop_front();
               if (rsp_left_out !== want.left) begin
                  $display("%0t: left_out mismatch, expected %0d, actual %0d",
                           $time, want.left, rsp_left_out);
                  errors++;
               end
               if (rsp_right_out !== want.right) begin
                  $display("%0t: right_out mismatch, expected %0d, actual %0d",
                           $time, want.right, rsp_right_out);
                  errors++;
               end
            end
         end

         // watchdog on cycles without any transfer
         if (req_taken || rsp_taken || csr_write_en) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t: no progress, %0d responses outstanding",
                     $time, expected_out.size());
            $display("simulation failed");
            $finish;
         end
      end
   end

   task automatic queue_pair(sample_type l, sample_type r);
      stereo_type p;
      p.left  = l;
      p.right = r;
      pending_pairs.push_back(p);
      requests_queued++;
   endtask

   // four back-to-back register writes, starting at a falling edge
   task automatic load_config(logic [CSR_DATA_W-1:0] base, logic [CSR_DATA_W-1:0] depth,
                              logic [CSR_DATA_W-1:0] level, logic [CSR_DATA_W-1:0] step);
      csr_write_en <= 1'b1;
      csr_index    <= CSR_BASE_DELAY;
      csr_wdata    <= base;
      @(negedge clock);
      csr_index <= CSR_MOD_DEPTH;
      csr_wdata <= depth;
      @(negedge clock);
      csr_index <= CSR_WET_LEVEL;
      csr_wdata <= level;
      @(negedge clock);
      csr_index <= CSR_PHASE_STEP;
      csr_wdata <= step;
      @(negedge clock);
      csr_write_en <= 1'b0;
   endtask

   // all requests taken and answered, then let the pipeline go quiet
   task automatic wait_drained();
      while (requests_taken != requests_queued || expected_out.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   initial begin : stimulus
      logic [CSR_DATA_W-1:0] base;
      logic [CSR_DATA_W-1:0] depth;
      logic [CSR_DATA_W-1:0] level;
      logic [CSR_DATA_W-1:0] step;

      repeat (9) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset settings: taps land on the cleared store, output is the dry input
      queue_pair(SAMPLE_MAX, SAMPLE_MIN);
      queue_pair(-16'sd1, 16'sd0);
      wait_drained();

      // zero delay reads the current input, full wet gain drives saturation
      load_config(0, 0, 65535, 0);
      queue_pair(SAMPLE_MAX, SAMPLE_MAX);
      queue_pair(SAMPLE_MIN, SAMPLE_MIN);
      queue_pair(16'sd1, -16'sd1);
      queue_pair(16'sd0, 16'sd0);
      wait_drained();

      // half-sample delay blends current and previous entries, quadrature lfo
      load_config(128, 0, 32768, 31'h4000_0000);
      queue_pair(16'sd1000, -16'sd1000);
      queue_pair(SAMPLE_MIN, SAMPLE_MAX);
      queue_pair(16'sd12345, -16'sd12345);
      wait_drained();

      // out-of-range writes get masked: widest delays, wet gain masked to zero
      load_config(31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_0000, 31'h7FFF_FFFF);
      queue_pair(SAMPLE_MAX, SAMPLE_MIN);
      queue_pair(-16'sd1, 16'sd1);
      wait_drained();

      // full modulation depth on top of a short base delay
      load_config(512, 2096896, 65535, 31'h4000_0000);
      repeat (4) queue_pair(any_sample(), any_sample());
      wait_drained();

      // random settings, mostly short delays so taps hit recent samples
      for (int ph = 0; ph < PHASES; ph++) begin
         case ($urandom_range(0, 3))
            0: base = CSR_DATA_W'($urandom_range(0, 8 * 256));
            1: base = CSR_DATA_W'($urandom_range(0, 300 * 256));
            2: base = CSR_DATA_W'($urandom);
            default: base = '0;
         endcase
         case ($urandom_range(0, 3))
            0: depth = CSR_DATA_W'($urandom_range(0, 8 * 256));
            1: depth = CSR_DATA_W'($urandom_range(0, 64 * 256));
            2: depth = CSR_DATA_W'($urandom);
            default: depth = CSR_DATA_W'(2096896);
         endcase
         level = ($urandom_range(0, 4) == 0) ? CSR_DATA_W'(65535) : CSR_DATA_W'($urandom);
         case ($urandom_range(0, 3))
            0: step = CSR_DATA_W'($urandom_range(0, 1 << 24));
            1: step = CSR_DATA_W'($urandom);
            2: step = 31'h4000_0000;
            default: step = CSR_DATA_W'($urandom_range(0, 255));
         endcase
         load_config(base, depth, level, step);

         steady_mode = (ph == 2);
         // receiver holds off while the sender keeps offering
         if (ph == 5) hold_asks++;
         repeat (PHASE_ITEMS) queue_pair(any_sample(), any_sample());
         wait_drained();
      end
      steady_mode = 1'b0;

      if (errors == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
